/* hw/rtl/sts_pkg.sv */
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, codes and default sizes of the sparse chunked tile store.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int DEF_TILE_SHIFT      = 4;
    localparam int DEF_HEAD_ENTRIES    = 64;
    localparam int DEF_OVERFLOW_CHUNKS = 64;
    localparam int DEF_SAFE_MARGIN     = 256;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ABSENT   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_RESERVED = 2'd3;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_RD,
        S_CHK,
        S_CLAIM,
        S_FILL,
        S_CRD,
        S_DONE
    } t_state;

    // Status handed from the hash unit to the controller.
    typedef struct packed {
        logic done;
        logic reserved;
    } t_hash_sts;

    function automatic logic value_empty(input logic [31:0] v);
        value_empty = (v == 32'd1) || (v == 32'd3) || (v == 32'd4);
    endfunction

endpackage

/* hw/rtl/sts_hash.sv */
// ----------------------------------------------------------------------------
// sts_hash
// Checks the chunk key against the reserved margin and reduces the key hash
// to a head entry, by a mask or by a reciprocal multiplication.
// ----------------------------------------------------------------------------
module sts_hash #(
    parameter int HEAD_ENTRIES = sts_pkg::DEF_HEAD_ENTRIES,
    parameter int SAFE_MARGIN  = sts_pkg::DEF_SAFE_MARGIN,
    parameter int SLOT_W       = $clog2(HEAD_ENTRIES)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [31:0]           i_cx,
    input  logic [31:0]           i_cy,
    input  logic [31:0]           i_cz,
    output sts_pkg::t_hash_sts    o_sts,
    output logic [SLOT_W-1:0]     o_slot
);

    localparam logic [31:0] KEY_LO = 32'(SAFE_MARGIN);
    localparam logic [31:0] KEY_HI = 32'hFFFF_FFFF - 32'(SAFE_MARGIN);
    localparam logic IS_POW2 = ((HEAD_ENTRIES & (HEAD_ENTRIES - 1)) == 0);
    // Rounded-up reciprocal: floor(h * RECIP / 2^RSH) is the exact quotient
    // for every 32-bit hash.
    localparam int RSH = 32 + SLOT_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RSH) + 64'(HEAD_ENTRIES) - 64'd1) / 64'(HEAD_ENTRIES);
    localparam logic [32:0] RECIP = RECIP_FULL[32:0];

    logic [31:0]       r_h;
    logic [31:0]       r_q;
    logic [SLOT_W-1:0] r_rem;
    logic              r_ph_q;
    logic              r_ph_r;
    logic              r_done;
    logic              r_rsv;

    logic [31:0]       hash;
    logic              rsv;
    logic [64:0]       prod;
    logic [31:0]       quot;
    logic [31:0]       diff;

    always_comb begin
        hash = 32'd19 * i_cx + 32'd7 * i_cy + 32'd3 * i_cz;
        rsv  = !((i_cx > KEY_LO) && (i_cx < KEY_HI) &&
                 (i_cy > KEY_LO) && (i_cy < KEY_HI) &&
                 (i_cz > KEY_LO) && (i_cz < KEY_HI));
        prod = 65'(r_h) * 65'(RECIP);
        quot = 32'(prod >> RSH);
        diff = r_h - 32'(r_q * 32'(HEAD_ENTRIES));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph_q <= 1'b0;
            r_ph_r <= 1'b0;
            r_done <= 1'b0;
        end else begin
            // A power-of-two table takes the low hash bits at once.
            r_ph_q <= i_start && !(IS_POW2 || rsv);
            r_ph_r <= r_ph_q;
            r_done <= (i_start && (IS_POW2 || rsv)) || r_ph_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rsv <= rsv;
            r_h   <= hash;
        end
        if (r_ph_q) begin
            r_q <= quot;
        end
        if (i_start) begin
            r_rem <= hash[SLOT_W-1:0];
        end else if (r_ph_r) begin
            r_rem <= diff[SLOT_W-1:0];
        end
    end

    assign o_sts.done     = r_done;
    assign o_sts.reserved = r_rsv;
    assign o_slot         = r_rem;

endmodule

/* hw/rtl/sts_keymem.sv */
// ----------------------------------------------------------------------------
// sts_keymem
// Chunk key and chain link memory, with per-entry occupied and linked bits.
// ----------------------------------------------------------------------------
module sts_keymem #(
    parameter int TOTAL = sts_pkg::DEF_HEAD_ENTRIES + sts_pkg::DEF_OVERFLOW_CHUNKS,
    parameter int EW    = $clog2(TOTAL)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_re,
    input  logic [EW-1:0] i_raddr,
    output logic [95:0]   o_rkey,
    output logic [EW-1:0] o_rnext,
    output logic          o_rvalid,
    output logic          o_rlinked,
    input  logic          i_we,
    input  logic [EW-1:0] i_waddr,
    input  logic [95:0]   i_wkey,
    input  logic [EW-1:0] i_wnext,
    input  logic          i_wlinked
);

    logic [EW+95:0] r_mem [TOTAL];
    logic [TOTAL-1:0] r_valid;
    logic [TOTAL-1:0] r_linked;
    logic [EW+95:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wnext, i_wkey};
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_linked  <= '0;
            o_rvalid  <= 1'b0;
            o_rlinked <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr]  <= 1'b1;
                r_linked[i_waddr] <= i_wlinked;
            end
            if (i_re) begin
                o_rvalid  <= r_valid[i_raddr];
                o_rlinked <= r_linked[i_raddr];
            end
        end
    end

    assign o_rkey  = r_rdata[95:0];
    assign o_rnext = r_rdata[EW+95:96];

endmodule

/* hw/rtl/sts_cellmem.sv */
// ----------------------------------------------------------------------------
// sts_cellmem
// Tile cell memory, one 32-bit cell per address, registered read.
// ----------------------------------------------------------------------------
module sts_cellmem #(
    parameter int DEPTH = 32768,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* hw/rtl/sparse_chunked_tile_store.sv */
// A read that hits the head entry passes the states HASH, RD, CHK, CRD and DONE before its
// result is registered; a write hit skips CRD, and each chain link walked adds RD and CHK.
// A non-power-of-two head count adds the reciprocal quotient and remainder registers.
// Creating a chunk adds the CLAIM state and the fill of its cells, one per cycle.
// One item is in work at a time; the next is taken once the result is registered.
// Reset (synchronous, active low) clears occupied, link bits and pool count at once.
// ----------------------------------------------------------------------------
// sparse_chunked_tile_store
// Sparse 3D tile store: a chained hash table of chunks held in a key memory
// and a cell memory, walked by a read-check-write controller.
// ----------------------------------------------------------------------------
module sparse_chunked_tile_store #(
    parameter int TILE_SHIFT      = sts_pkg::DEF_TILE_SHIFT,
    parameter int HEAD_ENTRIES    = sts_pkg::DEF_HEAD_ENTRIES,
    parameter int OVERFLOW_CHUNKS = sts_pkg::DEF_OVERFLOW_CHUNKS,
    parameter int SAFE_MARGIN     = sts_pkg::DEF_SAFE_MARGIN
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [127:0] i_s_axis_tdata,   // tile_x, tile_y, tile_z, write_value
    input  logic [0:0]   i_s_axis_tuser,   // kind
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [31:0]  o_m_axis_tdata,   // read_value
    output logic [2:0]   o_m_axis_tuser    // is_empty, status
);

    localparam int OFF_W  = 2 * TILE_SHIFT;
    localparam int TOTAL  = HEAD_ENTRIES + OVERFLOW_CHUNKS;
    localparam int EW     = $clog2(TOTAL);
    localparam int SLOT_W = $clog2(HEAD_ENTRIES);
    localparam int USED_W = $clog2(OVERFLOW_CHUNKS + 1);
    localparam int CELL_AW = EW + OFF_W;

    // Request registers.
    logic              r_kind;
    logic [95:0]       r_key;
    logic [OFF_W-1:0]  r_off;
    logic [31:0]       r_wv;

    sts_pkg::t_state   r_state, n_state;
    logic [EW-1:0]     r_e, n_e;
    logic [OFF_W-1:0]  r_fill, n_fill;
    logic [USED_W-1:0] r_used, n_used;
    logic [31:0]       r_value, n_value;
    logic [1:0]        r_status, n_status;

    logic              r_ovalid;
    logic [31:0]       r_odata;
    logic [2:0]        r_ouser;

    logic              accept;
    logic [31:0]       in_cx, in_cy, in_cz;

    sts_pkg::t_hash_sts hash_sts;
    logic [SLOT_W-1:0]  head_idx;

    logic              km_re, km_we, km_wlinked;
    logic [EW-1:0]     km_raddr, km_waddr, km_wnext, km_rnext;
    logic [95:0]       km_wkey, km_rkey;
    logic              km_rvalid, km_rlinked;

    logic              cm_we, cm_re;
    logic [CELL_AW-1:0] cm_waddr, cm_raddr;
    logic [31:0]       cm_wdata, cm_rdata;

    logic              match;
    logic              pool_full;
    logic              out_free;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == sts_pkg::S_IDLE);

    assign in_cx = i_s_axis_tdata[31:0] >> TILE_SHIFT;
    assign in_cy = i_s_axis_tdata[63:32] >> TILE_SHIFT;
    assign in_cz = i_s_axis_tdata[95:64];

    sts_hash #(
        .HEAD_ENTRIES (HEAD_ENTRIES),
        .SAFE_MARGIN  (SAFE_MARGIN),
        .SLOT_W       (SLOT_W)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_cx    (in_cx),
        .i_cy    (in_cy),
        .i_cz    (in_cz),
        .o_sts   (hash_sts),
        .o_slot  (head_idx)
    );

    sts_keymem #(
        .TOTAL (TOTAL),
        .EW    (EW)
    ) u_keymem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_re      (km_re),
        .i_raddr   (km_raddr),
        .o_rkey    (km_rkey),
        .o_rnext   (km_rnext),
        .o_rvalid  (km_rvalid),
        .o_rlinked (km_rlinked),
        .i_we      (km_we),
        .i_waddr   (km_waddr),
        .i_wkey    (km_wkey),
        .i_wnext   (km_wnext),
        .i_wlinked (km_wlinked)
    );

    sts_cellmem #(
        .DEPTH (TOTAL * (1 << OFF_W)),
        .AW    (CELL_AW)
    ) u_cellmem (
        .i_clk   (i_clk),
        .i_we    (cm_we),
        .i_waddr (cm_waddr),
        .i_wdata (cm_wdata),
        .i_re    (cm_re),
        .i_raddr (cm_raddr),
        .o_rdata (cm_rdata)
    );

    assign match     = km_rvalid && (km_rkey == r_key);
    assign pool_full = (r_used >= USED_W'(OVERFLOW_CHUNKS));
    assign out_free  = !r_ovalid || i_m_axis_tready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sts_pkg::S_IDLE: begin
                if (accept) n_state = sts_pkg::S_HASH;
            end
            sts_pkg::S_HASH: begin
                if (hash_sts.done) begin
                    n_state = hash_sts.reserved ? sts_pkg::S_DONE : sts_pkg::S_RD;
                end
            end
            sts_pkg::S_RD: n_state = sts_pkg::S_CHK;
            sts_pkg::S_CHK: begin
                priority if (match) begin
                    n_state = (r_kind == sts_pkg::KIND_WRITE) ? sts_pkg::S_DONE
                                                              : sts_pkg::S_CRD;
                end else if (r_kind == sts_pkg::KIND_WRITE) begin
                    if (!km_rvalid)       n_state = sts_pkg::S_CLAIM;
                    else if (km_rlinked)  n_state = sts_pkg::S_RD;
                    else if (pool_full)   n_state = sts_pkg::S_DONE;
                    else                  n_state = sts_pkg::S_CLAIM;
                end else begin
                    n_state = km_rlinked ? sts_pkg::S_RD : sts_pkg::S_DONE;
                end
            end
            sts_pkg::S_CLAIM: n_state = sts_pkg::S_FILL;
            sts_pkg::S_FILL: begin
                if (r_fill == '1) n_state = sts_pkg::S_DONE;
            end
            sts_pkg::S_CRD: n_state = sts_pkg::S_DONE;
            sts_pkg::S_DONE: begin
                if (out_free) n_state = sts_pkg::S_IDLE;
            end
            default: n_state = sts_pkg::S_IDLE;
        endcase
    end

    // Datapath controls and memory ports.
    always_comb begin
        n_e      = r_e;
        n_fill   = r_fill;
        n_used   = r_used;
        n_value  = r_value;
        n_status = r_status;
        km_re      = 1'b0;
        km_raddr   = r_e;
        km_we      = 1'b0;
        km_waddr   = r_e;
        km_wkey    = r_key;
        km_wnext   = '0;
        km_wlinked = 1'b0;
        cm_we      = 1'b0;
        cm_waddr   = {r_e, r_off};
        cm_wdata   = r_wv;
        cm_re      = 1'b0;
        cm_raddr   = {r_e, r_off};
        unique case (r_state)
            sts_pkg::S_IDLE: begin
                n_value  = '0;
                n_status = sts_pkg::ST_OK;
            end
            sts_pkg::S_HASH: begin
                if (hash_sts.done) begin
                    n_e = EW'(head_idx);
                    if (hash_sts.reserved) n_status = sts_pkg::ST_RESERVED;
                end
            end
            sts_pkg::S_RD: km_re = 1'b1;
            sts_pkg::S_CHK: begin
                priority if (match) begin
                    if (r_kind == sts_pkg::KIND_WRITE) cm_we = 1'b1;
                    else                               cm_re = 1'b1;
                end else if (r_kind == sts_pkg::KIND_WRITE) begin
                    if (!km_rvalid) begin
                        // Empty head entry: claim it in place.
                    end else if (km_rlinked) begin
                        n_e = km_rnext;
                    end else if (pool_full) begin
                        n_status = sts_pkg::ST_FULL;
                    end else begin
                        // Link the tail to the next pool entry; keep its key.
                        n_e        = EW'(HEAD_ENTRIES) + EW'(r_used);
                        n_used     = r_used + USED_W'(1);
                        km_we      = 1'b1;
                        km_wkey    = km_rkey;
                        km_wnext   = EW'(HEAD_ENTRIES) + EW'(r_used);
                        km_wlinked = 1'b1;
                    end
                end else begin
                    if (km_rlinked) n_e = km_rnext;
                    else            n_status = sts_pkg::ST_ABSENT;
                end
            end
            sts_pkg::S_CLAIM: begin
                km_we  = 1'b1;
                n_fill = '0;
            end
            sts_pkg::S_FILL: begin
                // New chunk cells read as 1, except the one being written.
                cm_we    = 1'b1;
                cm_waddr = {r_e, r_fill};
                cm_wdata = (r_fill == r_off) ? r_wv : 32'd1;
                n_fill   = r_fill + OFF_W'(1);
            end
            sts_pkg::S_CRD: n_value = cm_rdata;
            sts_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_s_axis_tuser[0];
            r_key  <= {in_cz, in_cy, in_cx};
            r_off  <= {i_s_axis_tdata[32 +: TILE_SHIFT], i_s_axis_tdata[0 +: TILE_SHIFT]};
            r_wv   <= i_s_axis_tdata[127:96];
        end
        r_e      <= n_e;
        r_fill   <= n_fill;
        r_value  <= n_value;
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sts_pkg::S_IDLE;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            if (r_state == sts_pkg::S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sts_pkg::S_DONE && out_free) begin
            r_odata <= r_value;
            r_ouser <= {r_status,
                        (r_kind == sts_pkg::KIND_READ) && (r_status == sts_pkg::ST_OK) &&
                        sts_pkg::value_empty(r_value)};
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

endmodule

/* verif/sparse_chunked_tile_store_test.sv */
// ----------------------------------------------------------------------------
// sparse_chunked_tile_store_test
// Drives reads and writes of tiles into the sparse chunked tile store and
// compares every result with a local model of the chained hash table.
// ----------------------------------------------------------------------------
module sparse_chunked_tile_store_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SHIFT     = sts_pkg::DEF_TILE_SHIFT;
    localparam int SLOTS     = sts_pkg::DEF_HEAD_ENTRIES;
    localparam int POOL      = sts_pkg::DEF_OVERFLOW_CHUNKS;
    localparam int MARGIN    = sts_pkg::DEF_SAFE_MARGIN;
    localparam int DIM       = 1 << SHIFT;
    localparam int CELLS     = DIM * DIM;
    localparam int ENTRIES   = SLOTS + POOL;
    localparam int WDOG_MAX  = 20000;
    localparam logic K_RD    = sts_pkg::KIND_READ;
    localparam logic K_WR    = sts_pkg::KIND_WRITE;

    typedef struct packed {
        logic [31:0] value;
        logic        empty;
        logic [1:0]  status;
    } t_tile_result;

    // Local copy of the hash table used to predict each result.
    class tile_scoreboard;
        logic [31:0]  key_x [ENTRIES];
        logic [31:0]  key_y [ENTRIES];
        logic [31:0]  key_z [ENTRIES];
        int           next_e [ENTRIES];
        bit           linked [ENTRIES];
        logic [31:0]  cells [ENTRIES*CELLS];
        int           pool_used;
        t_tile_result pending[$];
        int           errors;
        int           n_checked;
        int           n_status[4];

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                key_x[i] = 0; key_y[i] = 0; key_z[i] = 0;
                next_e[i] = 0; linked[i] = 0;
            end
            pool_used = 0;
            errors = 0;
            n_checked = 0;
        endfunction

        function bit key_ok(logic [31:0] k);
            return k > MARGIN && k < (32'hFFFF_FFFF - MARGIN);
        endfunction

        function void claim(int e, logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
            key_x[e] = cx; key_y[e] = cy; key_z[e] = cz;
            linked[e] = 0; next_e[e] = 0;
            for (int i = 0; i < CELLS; i++) cells[e*CELLS+i] = 1;
        endfunction

        function void note_item(logic kind, logic [31:0] tx, logic [31:0] ty,
                                logic [31:0] tz, logic [31:0] wv);
            logic [31:0]  cx, cy, cz, h;
            int           e, off;
            bit           found;
            t_tile_result r;
            cx = tx >> SHIFT;
            cy = ty >> SHIFT;
            cz = tz;
            off = int'(ty[SHIFT-1:0]) * DIM + int'(tx[SHIFT-1:0]);
            found = 0;
            r = '0;
            r.status = sts_pkg::ST_OK;
            if (!key_ok(cx) || !key_ok(cy) || !key_ok(cz)) begin
                r.status = sts_pkg::ST_RESERVED;
            end else begin
                h = 32'd19 * cx + 32'd7 * cy + 32'd3 * cz;
                e = int'(h % SLOTS);
                for (int s = 0; s <= ENTRIES; s++) begin
                    if (key_x[e] == cx && key_y[e] == cy && key_z[e] == cz) begin
                        found = 1;
                        break;
                    end
                    if (kind == K_WR) begin
                        if (key_x[e] == 0) begin
                            claim(e, cx, cy, cz);
                            found = 1;
                            break;
                        end
                        if (!linked[e]) begin
                            if (pool_used >= POOL) begin
                                r.status = sts_pkg::ST_FULL;
                                break;
                            end
                            linked[e] = 1;
                            next_e[e] = SLOTS + pool_used;
                            pool_used++;
                            e = next_e[e];
                            claim(e, cx, cy, cz);
                            found = 1;
                            break;
                        end
                    end else if (!linked[e]) begin
                        break;
                    end
                    e = next_e[e];
                    if (e >= ENTRIES) break;
                end
                if (found) begin
                    if (kind == K_WR) cells[e*CELLS+off] = wv;
                    else r.value = cells[e*CELLS+off];
                end else if (kind == K_RD) begin
                    r.status = sts_pkg::ST_ABSENT;
                end else begin
                    r.status = sts_pkg::ST_FULL;
                end
            end
            r.empty = (kind == K_RD && r.status == sts_pkg::ST_OK &&
                       (r.value == 1 || r.value == 3 || r.value == 4));
            pending.push_back(r);
        endfunction

        function void check_result(logic [31:0] value, logic [2:0] user);
            t_tile_result x;
            if (pending.size() == 0) begin
                $error("result with nothing expected: value %0h user %0h", value, user);
                errors++;
                return;
            end
            x = pending.pop_front();
            n_checked++;
            n_status[x.status]++;
            if (value !== x.value) begin
                $error("read_value: expected %0h, got %0h", x.value, value);
                errors++;
            end
            if (user[0] !== x.empty) begin
                $error("is_empty: expected %0d, got %0d", x.empty, user[0]);
                errors++;
            end
            if (user[2:1] !== x.status) begin
                $error("status: expected %0d, got %0d", x.status, user[2:1]);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [127:0] i_s_axis_tdata;   // tile_x, tile_y, tile_z, write_value
    logic [0:0]   i_s_axis_tuser;   // kind
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [31:0]  o_m_axis_tdata;   // read_value
    logic [2:0]   o_m_axis_tuser;   // is_empty, status

    sparse_chunked_tile_store uut (.*);

    tile_scoreboard board;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    int  wdog;
    // Chunk keys already created, reused to hit existing chunks.
    logic [31:0] used_cx[$], used_cy[$], used_cz[$];

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver side: random stalls, or a forced hold during the pressure phase.
    always @(negedge i_clk) begin
        i_m_axis_tready <= i_rst_n && !recv_hold &&
                           ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                board.check_result(o_m_axis_tdata, o_m_axis_tuser);
            if ((o_m_axis_tvalid && i_m_axis_tready) ||
                (i_s_axis_tvalid && o_s_axis_tready))
                wdog = 0;
            else
                wdog++;
            if (wdog >= WDOG_MAX) begin
                $display("timeout: no item moved for %0d cycles", WDOG_MAX);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Valid stays up with the old item until the next one is set up at the
    // same falling edge, or an idle cycle or the end of the run drops it.
    task automatic send_tile(logic kind, logic [31:0] tx, logic [31:0] ty,
                             logic [31:0] tz, logic [31:0] wv);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1;
        i_s_axis_tuser <= kind;
        i_s_axis_tdata <= {wv, tz, ty, tx};
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_item(kind, tx, ty, tz, wv);
        @(negedge i_clk);
    endtask

    // Valid chunk coordinate, often from a small set so hash chains collide.
    function automatic logic [31:0] pick_key(int sel);
        case (sel)
            0: return 32'(MARGIN + 1 + $urandom_range(40));
            1: return 32'hFFFF_FFFF - MARGIN - 1 - $urandom_range(3);
            default: return 32'(MARGIN + 1) + ($urandom() % 32'hFFFF_FD00);
        endcase
    endfunction

    task automatic random_item();
        logic        kind;
        logic [31:0] cx, cy, cz, tx, ty, tz;
        int          r, k;
        r = $urandom_range(99);
        kind = 1'($urandom_range(1));
        if (r < 8) begin
            // Noise: any coordinates, almost never reserved keys.
            tx = $urandom(); ty = $urandom(); tz = $urandom();
        end else begin
            if (used_cx.size() > 0 && r < 70) begin
                k = $urandom_range(used_cx.size() - 1);
                cx = used_cx[k]; cy = used_cy[k]; cz = used_cz[k];
            end else begin
                cx = pick_key($urandom_range(4) == 0 ? 1 : ($urandom_range(1) ? 0 : 2));
                cy = pick_key($urandom_range(1) ? 0 : 2);
                cz = pick_key($urandom_range(2));
                if (kind == K_WR && cx < 32'h0FFF_FFFF) begin
                    used_cx.push_back(cx); used_cy.push_back(cy); used_cz.push_back(cz);
                end
            end
            tx = (cx << SHIFT) | $urandom_range(DIM - 1);
            ty = (cy << SHIFT) | $urandom_range(DIM - 1);
            tz = cz;
        end
        send_tile(kind, tx, ty, tz, $urandom_range(3) == 0 ? $urandom_range(5) : $urandom());
    endtask

    initial begin
        logic [31:0] lo, hi;
        board = new();
        i_rst_n = 0;
        i_s_axis_tvalid = 0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 0;
        lo = 32'(MARGIN + 1);
        hi = 32'hFFFF_FFFF - MARGIN - 1;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: reserved margins, absent reads, fill value, empty codes.
        send_tile(K_RD, 32'd0, 32'd0, 32'd0, 32'd0);
        send_tile(K_WR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_tile(K_WR, 32'(MARGIN) << SHIFT, lo << SHIFT, lo, 32'd5);
        send_tile(K_WR, lo << SHIFT, lo << SHIFT, 32'hFFFF_FFFF - MARGIN, 32'd5);
        send_tile(K_RD, lo << SHIFT, lo << SHIFT, lo, 32'd0);
        send_tile(K_WR, lo << SHIFT, lo << SHIFT, lo, 32'hFFFF_FFFF);
        send_tile(K_RD, lo << SHIFT, lo << SHIFT, lo, 32'd0);
        send_tile(K_RD, (lo << SHIFT) | 15, (lo << SHIFT) | 15, lo, 32'd0);
        for (int v = 2; v <= 5; v++) begin
            send_tile(K_WR, (lo << SHIFT) | 3, lo << SHIFT, lo, 32'(v));
            send_tile(K_RD, (lo << SHIFT) | 3, lo << SHIFT, lo, 32'd0);
        end
        send_tile(K_WR, 32'hFFFF_FFF0 - (MARGIN << SHIFT) - 16,
                  32'hFFFF_FFF0 - (MARGIN << SHIFT) - 16, hi, 32'h8000_0000);
        send_tile(K_RD, 32'hFFFF_FFF0 - (MARGIN << SHIFT) - 16,
                  32'hFFFF_FFF0 - (MARGIN << SHIFT) - 16, hi, 32'd0);
        // Same head entry, different key: 19*64 added to the hash keeps it.
        send_tile(K_WR, (lo + 64) << SHIFT, lo << SHIFT, lo, 32'd0);
        send_tile(K_RD, (lo + 64) << SHIFT, lo << SHIFT, lo, 32'd0);
        send_tile(K_RD, (lo + 128) << SHIFT, lo << SHIFT, lo, 32'd0);

        // Pressure: receiver holds off while items keep coming.
        recv_hold = 1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                recv_hold = 0;
            end
            repeat (20) random_item();
        join

        send_idle_pct = 16; recv_idle_pct = 77;
        repeat (330) random_item();
        send_idle_pct = 77; recv_idle_pct = 16;
        repeat (330) random_item();
        send_idle_pct = 0; recv_idle_pct = 0;
        // Exhaust the pool: many new chunks all in one head entry.
        for (int i = 0; i < POOL + 8; i++)
            send_tile(K_WR, (lo + 32'(64 * (i + 3))) << SHIFT, (lo + 3) << SHIFT,
                      lo, $urandom());
        repeat (330) random_item();
        i_s_axis_tvalid <= 0;

        while (board.pending.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Checked %0d results: %0d ok, %0d absent, %0d pool full, %0d reserved.",
                 board.n_checked, board.n_status[0], board.n_status[1],
                 board.n_status[2], board.n_status[3]);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

/* sparse_chunked_tile_store.f */
hw/rtl/sts_pkg.sv
hw/rtl/sts_hash.sv
hw/rtl/sts_keymem.sv
hw/rtl/sts_cellmem.sv
hw/rtl/sparse_chunked_tile_store.sv
verif/sparse_chunked_tile_store_test.sv
